>>> rtl/aabb_all_pairs_overlap_defines.svh
// Assertion macros shared by the box overlap checker's RTL files.
`ifndef AABB_ALL_PAIRS_OVERLAP_DEFINES_SVH
`define AABB_ALL_PAIRS_OVERLAP_DEFINES_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define AAPO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define AAPO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AAPO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define AAPO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/aapo_pkg.sv
// Shared types and constants of the box overlap checker.
`default_nettype none

package aapo_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int SLOT_W        = 3;
    localparam int MAX_RESULTS   = 29;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] FUNC_CREATE     = 2'd0;
    localparam logic [1:0] FUNC_ERASE      = 2'd1;
    localparam logic [1:0] FUNC_SET_ACTIVE = 2'd2;
    localparam logic [1:0] FUNC_TICK       = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [SLOT_W-1:0]  slot;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic               active_value;
        logic               has_handler;
    } in_beat_t;

    typedef struct packed {
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic              pair_found;
        logic              first_handler;
        logic              second_handler;
        logic              table_full;
        logic              last;
    } out_beat_t;

    typedef struct packed {
        logic create;
        logic erase;
        logic set_active;
        logic issue;
        logic issue_final;
    } cmd_t;

    typedef struct packed {
        logic flush;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/aapo_ctrl.sv
// Controller: command decode and the pair walk sequencer.
`default_nettype none
`include "aabb_all_pairs_overlap_defines.svh"

module aapo_ctrl #(
    parameter int SLOTS = aapo_pkg::SLOTS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [1:0]                 func,
    input  wire aapo_pkg::stat_t            status,
    output aapo_pkg::cmd_t                  cmd,
    output logic [$clog2(SLOTS)-1:0]        pair_i,
    output logic [$clog2(SLOTS)-1:0]        pair_j,
    output logic                            busy
);
    import aapo_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_I = IDX_W'(SLOTS - 2);
    localparam logic [IDX_W-1:0] LAST_J = IDX_W'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] pair_i_reg;
    logic [IDX_W-1:0] pair_i_next;
    logic [IDX_W-1:0] pair_j_reg;
    logic [IDX_W-1:0] pair_j_next;
    logic             accept;
    logic             final_pair;

    assign accept     = start && (state_reg == ST_IDLE);
    assign final_pair = (pair_i_reg == LAST_I) && (pair_j_reg == LAST_J);

    always_comb
    begin
        state_next  = state_reg;
        pair_i_next = pair_i_reg;
        pair_j_next = pair_j_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_CREATE:     cmd.create     = 1'b1;
                        FUNC_ERASE:      cmd.erase      = 1'b1;
                        FUNC_SET_ACTIVE: cmd.set_active = 1'b1;
                        FUNC_TICK:
                        begin
                            state_next  = ST_WALK;
                            pair_i_next = '0;
                            pair_j_next = IDX_W'(1);
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.issue       = 1'b1;
                cmd.issue_final = final_pair;
                if (final_pair)
                begin
                    state_next = ST_DRAIN;
                end
                else if (pair_j_reg == LAST_J)
                begin
                    pair_i_next = pair_i_reg + IDX_W'(1);
                    pair_j_next = pair_i_reg + IDX_W'(2);
                end
                else
                begin
                    pair_j_next = pair_j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (status.flush)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pair_i_reg <= '0;
            pair_j_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pair_i_reg <= pair_i_next;
            pair_j_reg <= pair_j_next;
        end
    end

    assign pair_i = pair_i_reg;
    assign pair_j = pair_j_reg;
    assign busy   = (state_reg != ST_IDLE);

    `AAPO_ASSERT_SAME(a_pair_ordered, clk, rst_n, cmd.issue, pair_i_reg < pair_j_reg, "pair walk issued i >= j")
    `AAPO_ASSERT_NEXT(a_walk_starts, clk, rst_n, accept && (func == FUNC_TICK), (pair_i_reg == '0) && (pair_j_reg == IDX_W'(1)), "tick did not start at the first pair")
    `AAPO_ASSERT_NEXT(a_drain_ends, clk, rst_n, (state_reg == ST_DRAIN) && status.flush, state_reg == ST_IDLE, "controller did not return to idle after flush")

endmodule

`default_nettype wire

>>> rtl/aapo_datapath.sv
// Datapath: box table, overlap compare pipeline and result register.
`default_nettype none
`include "aabb_all_pairs_overlap_defines.svh"

module aapo_datapath #(
    parameter int SLOTS = aapo_pkg::SLOTS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire aapo_pkg::cmd_t             cmd,
    input  wire logic [$clog2(SLOTS)-1:0]   pair_i,
    input  wire logic [$clog2(SLOTS)-1:0]   pair_j,
    input  wire aapo_pkg::in_beat_t         request,
    output aapo_pkg::stat_t                 status,
    output aapo_pkg::out_beat_t             result,
    output logic                            result_valid
);
    import aapo_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
    } geom_t;

    // Box table: flags in flip-flops, geometry in a two-read-port memory.
    geom_t            geom_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] active_reg;
    logic [SLOTS-1:0] handler_reg;

    // Lowest free slot.
    logic [IDX_W-1:0]        free_idx;
    logic                    table_full;
    logic [IDX_W+SLOT_W-1:0] free_wide;
    logic [IDX_W+SLOT_W-1:0] req_slot_wide;
    logic [IDX_W-1:0]        req_idx;
    logic                    req_in_range;

    always_comb
    begin
        free_idx   = '0;
        table_full = 1'b1;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_idx   = IDX_W'(s);
                table_full = 1'b0;
            end
        end
    end

    assign free_wide     = {{SLOT_W{1'b0}}, free_idx};
    assign req_slot_wide = {{IDX_W{1'b0}}, request.slot};
    assign req_idx       = req_slot_wide[IDX_W-1:0];
    assign req_in_range  = (int'(request.slot) < SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            active_reg  <= '0;
            handler_reg <= '0;
        end
        else
        begin
            if (cmd.create && !table_full)
            begin
                valid_reg[free_idx]   <= 1'b1;
                active_reg[free_idx]  <= 1'b1;
                handler_reg[free_idx] <= request.has_handler;
            end
            if (cmd.erase && req_in_range)
            begin
                valid_reg[req_idx] <= 1'b0;
            end
            if (cmd.set_active && req_in_range)
            begin
                active_reg[req_idx] <= request.active_value;
            end
        end
    end

    // Stage 1: registered reads of both boxes.
    geom_t            geom_a_reg;
    geom_t            geom_b_reg;
    logic             s1_valid_reg;
    logic             s1_final_reg;
    logic             s1_qual_reg;
    logic             s1_ha_reg;
    logic             s1_hb_reg;
    logic [IDX_W-1:0] s1_i_reg;
    logic [IDX_W-1:0] s1_j_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.create && !table_full)
        begin
            geom_mem[free_idx] <= '{x: request.x_pos, y: request.y_pos,
                                    w: request.box_width, h: request.box_height};
        end
    end

    always_ff @(posedge clk)
    begin
        geom_a_reg <= geom_mem[pair_i];
        geom_b_reg <= geom_mem[pair_j];
    end

    always_ff @(posedge clk)
    begin
        s1_qual_reg <= valid_reg[pair_i] && valid_reg[pair_j]
                    && active_reg[pair_i] && active_reg[pair_j];
        s1_ha_reg   <= handler_reg[pair_i];
        s1_hb_reg   <= handler_reg[pair_j];
        s1_i_reg    <= pair_i;
        s1_j_reg    <= pair_j;
    end

    // Stage 2: twice the center distance and the summed sizes per axis.
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] abs_dx;
    logic [16:0] abs_dy;

    assign dx     = {geom_a_reg.x[15], geom_a_reg.x} - {geom_b_reg.x[15], geom_b_reg.x};
    assign dy     = {geom_a_reg.y[15], geom_a_reg.y} - {geom_b_reg.y[15], geom_b_reg.y};
    assign abs_dx = dx[16] ? (17'd0 - dx) : dx;
    assign abs_dy = dy[16] ? (17'd0 - dy) : dy;

    logic [16:0]      dx2_reg;
    logic [16:0]      dy2_reg;
    logic [16:0]      sum_w_reg;
    logic [16:0]      sum_h_reg;
    logic             s2_valid_reg;
    logic             s2_final_reg;
    logic             s2_qual_reg;
    logic             s2_ha_reg;
    logic             s2_hb_reg;
    logic [IDX_W-1:0] s2_i_reg;
    logic [IDX_W-1:0] s2_j_reg;

    always_ff @(posedge clk)
    begin
        dx2_reg     <= {abs_dx[15:0], 1'b0};
        dy2_reg     <= {abs_dy[15:0], 1'b0};
        sum_w_reg   <= {1'b0, geom_a_reg.w} + {1'b0, geom_b_reg.w};
        sum_h_reg   <= {1'b0, geom_a_reg.h} + {1'b0, geom_b_reg.h};
        s2_qual_reg <= s1_qual_reg;
        s2_ha_reg   <= s1_ha_reg;
        s2_hb_reg   <= s1_hb_reg;
        s2_i_reg    <= s1_i_reg;
        s2_j_reg    <= s1_j_reg;
    end

    logic flush_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_final_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_final_reg <= 1'b0;
            flush_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s1_final_reg <= cmd.issue_final;
            s2_valid_reg <= s1_valid_reg;
            s2_final_reg <= s1_final_reg;
            flush_reg    <= s2_valid_reg && s2_final_reg;
        end
    end

    // Stage 3: strict compare. A hit is held back one place so that the
    // final one can carry the last mark when the walk ends.
    logic                    hit;
    logic                    take;
    logic [IDX_W+SLOT_W-1:0] s2_i_wide;
    logic [IDX_W+SLOT_W-1:0] s2_j_wide;
    out_beat_t               cur_pair;

    out_beat_t  pend_reg;
    out_beat_t  pend_next;
    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    out_beat_t  result_reg;
    out_beat_t  result_next;
    logic       result_valid_reg;
    logic       result_valid_next;

    assign hit  = s2_qual_reg && (dx2_reg < sum_w_reg) && (dy2_reg < sum_h_reg);
    assign take = s2_valid_reg && hit && (count_reg < CNT_W'(MAX_RESULTS));

    assign s2_i_wide = {{SLOT_W{1'b0}}, s2_i_reg};
    assign s2_j_wide = {{SLOT_W{1'b0}}, s2_j_reg};

    always_comb
    begin
        cur_pair                = '0;
        cur_pair.first_slot     = s2_i_wide[SLOT_W-1:0];
        cur_pair.second_slot    = s2_j_wide[SLOT_W-1:0];
        cur_pair.pair_found     = 1'b1;
        cur_pair.first_handler  = s2_ha_reg;
        cur_pair.second_handler = s2_hb_reg;
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = 1'b0;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        count_next        = count_reg;
        priority if (cmd.create)
        begin
            result_next       = '0;
            result_next.last  = 1'b1;
            result_valid_next = 1'b1;
            if (table_full)
            begin
                result_next.table_full = 1'b1;
            end
            else
            begin
                result_next.first_slot = free_wide[SLOT_W-1:0];
            end
        end
        else if (take)
        begin
            if (pend_valid_reg)
            begin
                result_next       = pend_reg;
                result_next.last  = 1'b0;
                result_valid_next = 1'b1;
            end
            pend_next       = cur_pair;
            pend_valid_next = 1'b1;
            count_next      = count_reg + CNT_W'(1);
        end
        else if (flush_reg)
        begin
            result_next       = pend_valid_reg ? pend_reg : '0;
            result_next.last  = 1'b1;
            result_valid_next = 1'b1;
            pend_valid_next   = 1'b0;
            count_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg   <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg   <= pend_valid_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign status.flush = flush_reg;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    `AAPO_ASSERT_NEXT(a_flush_emits_last, clk, rst_n, flush_reg, result_valid_reg && result_reg.last, "flush did not emit a last beat")
    `AAPO_ASSERT_SAME(a_flush_pipe_empty, clk, rst_n, flush_reg, !s1_valid_reg && !s2_valid_reg, "flush while compares in flight")
    `AAPO_ASSERT_SAME(a_create_idle_pipe, clk, rst_n, cmd.create, !s1_valid_reg && !s2_valid_reg && !pend_valid_reg, "create during a tick walk")
    `AAPO_ASSERT_SAME(a_count_bounded, clk, rst_n, pend_valid_reg, (count_reg != '0) && (count_reg <= CNT_W'(MAX_RESULTS)), "pair count out of range")

endmodule

`default_nettype wire

>>> rtl/aabb_all_pairs_overlap.sv
// Top level of the axis-aligned box table with all-pairs overlap search.
`default_nettype none

// A table of SLOTS boxes (center x/y signed, full width/height unsigned,
// 16 bits each) with an active flag and a handler bit per slot. A command
// beat is taken at a rising edge where start is high and busy is low.
// Create, erase and set active leave busy low, and create returns one
// result beat in the next cycle with the new slot or table_full. A tick
// walks every slot pair i<j, one pair per cycle through a three-stage
// compare pipeline (table read, distance and size sums, strict compare),
// and busy stays high until the final pair has left that pipeline. Each
// overlapping pair of valid, active boxes comes out as one beat; the last
// beat of the tick carries last, and a tick without overlaps gives one
// empty beat with only last set. At most 29 pair beats are reported per
// tick. result_valid is high for exactly one cycle per result beat and the
// receiver cannot hold beats off, so it must take every beat as it comes.
// Geometry of a slot is used in a compare only after create has written
// it; no clearing pass is needed after reset.
module aabb_all_pairs_overlap #(
    parameter int SLOTS = aapo_pkg::SLOTS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire aapo_pkg::in_beat_t  request,
    output aapo_pkg::out_beat_t      result,
    output logic                     result_valid
);
    import aapo_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    cmd_t             cmd;
    stat_t            status;
    logic [IDX_W-1:0] pair_i;
    logic [IDX_W-1:0] pair_j;

    // The controller decodes command beats and sequences the pair walk.
    aapo_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (request.func),
        .status (status),
        .cmd    (cmd),
        .pair_i (pair_i),
        .pair_j (pair_j),
        .busy   (busy)
    );

    // The datapath holds the table, compares boxes and drives result beats.
    aapo_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pair_i       (pair_i),
        .pair_j       (pair_j),
        .request      (request),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the box table with all-pairs overlap search.
`timescale 1ns / 100ps

module tb;
    import aapo_pkg::*;

    localparam int SLOTS       = SLOTS_DEFAULT;
    // The drain wait at the end covers the longest tick, a walk over every
    // slot pair, with a margin to spare.
    localparam int DRAIN_WAIT  = SLOTS * (SLOTS - 1) / 2 + 12;
    // The slowest legal run is about 350 commands, each a full tick plus a
    // sender gap. The limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 320;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_beat_t   request;
    out_beat_t  result;
    logic       result_valid;

    aabb_all_pairs_overlap #(
        .SLOTS(SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result      (result),
        .result_valid(result_valid)
    );

    // One row of the directed table. When known is set, the single result
    // beat of the row is typed in and is checked instead of the prediction.
    typedef struct {
        in_beat_t  req;
        bit        known;
        out_beat_t want;
    } directed_row_t;

    // Shadow copy of the box table that the predictor keeps in step with the
    // block. Geometry is only read for slots that create has written.
    logic               shadow_valid  [SLOTS];
    logic               shadow_active [SLOTS];
    logic               shadow_handler[SLOTS];
    logic signed [15:0] shadow_cx     [SLOTS];
    logic signed [15:0] shadow_cy     [SLOTS];
    logic [15:0]        shadow_w      [SLOTS];
    logic [15:0]        shadow_h      [SLOTS];

    out_beat_t     step_results[$];   // beats caused by the command just taken
    out_beat_t     due_results[$];    // beats predicted but not yet seen
    directed_row_t directed_rows[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int beats_sent    = 0;
    int ticks_sent    = 0;
    int pairs_seen    = 0;
    int full_creates  = 0;
    int most_pairs    = 0;

    // 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Global watchdog. It runs in its own process, so a hung handshake or a
    // missing result beat still ends the run with the fail message.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[%0t] watchdog expired after %0d cycles, %0d beats still due",
                     $realtime, cycle_count, due_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor. Applies one command to the shadow table and leaves the
    // result beats it causes in step_results.
    // ------------------------------------------------------------------
    function automatic bit boxes_touch(int i, int j);
        int dx;
        int dy;
        int sum_w;
        int sum_h;
        dx    = int'(shadow_cx[i]) - int'(shadow_cx[j]);
        dy    = int'(shadow_cy[i]) - int'(shadow_cy[j]);
        sum_w = int'(shadow_w[i]) + int'(shadow_w[j]);
        sum_h = int'(shadow_h[i]) + int'(shadow_h[j]);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        // Both compares are strict, so boxes that only share an edge do not
        // count as overlapping.
        return (2 * dx < sum_w) && (2 * dy < sum_h);
    endfunction

    task automatic predict_table_op(input in_beat_t cmd);
        out_beat_t beat;
        int        free_slot;
        step_results.delete();
        beat = '0;
        case (cmd.func)
            FUNC_CREATE:
            begin
                free_slot = -1;
                for (int s = SLOTS - 1; s >= 0; s--)
                    if (!shadow_valid[s])
                        free_slot = s;
                beat.last = 1'b1;
                if (free_slot < 0)
                begin
                    // The table is left alone when every slot is taken.
                    beat.table_full = 1'b1;
                end
                else
                begin
                    shadow_valid[free_slot]   = 1'b1;
                    shadow_active[free_slot]  = 1'b1;
                    shadow_handler[free_slot] = cmd.has_handler;
                    shadow_cx[free_slot]      = cmd.x_pos;
                    shadow_cy[free_slot]      = cmd.y_pos;
                    shadow_w[free_slot]       = cmd.box_width;
                    shadow_h[free_slot]       = cmd.box_height;
                    beat.first_slot           = free_slot[SLOT_W-1:0];
                end
                step_results.push_back(beat);
            end
            FUNC_ERASE:
            begin
                if (int'(cmd.slot) < SLOTS)
                    shadow_valid[cmd.slot] = 1'b0;
            end
            FUNC_SET_ACTIVE:
            begin
                // Writing the flag of a free slot is allowed; it has no effect
                // until a create overwrites it with 1 anyway.
                if (int'(cmd.slot) < SLOTS)
                    shadow_active[cmd.slot] = cmd.active_value;
            end
            default:
            begin
                // Tick: pairs i<j in ascending order, i in the outer loop.
                for (int i = 0; i < SLOTS; i++)
                    for (int j = i + 1; j < SLOTS; j++)
                        if (shadow_valid[i] && shadow_valid[j] &&
                            shadow_active[i] && shadow_active[j] &&
                            boxes_touch(i, j) && step_results.size() < MAX_RESULTS)
                        begin
                            beat                = '0;
                            beat.first_slot     = i[SLOT_W-1:0];
                            beat.second_slot    = j[SLOT_W-1:0];
                            beat.pair_found     = 1'b1;
                            beat.first_handler  = shadow_handler[i];
                            beat.second_handler = shadow_handler[j];
                            step_results.push_back(beat);
                        end
                if (step_results.size() > most_pairs)
                    most_pairs = step_results.size();
                if (step_results.size() == 0)
                begin
                    // A quiet tick still answers with one empty done beat.
                    beat      = '0;
                    beat.last = 1'b1;
                    step_results.push_back(beat);
                end
                else
                begin
                    step_results[step_results.size() - 1].last = 1'b1;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result monitor. The block cannot be stalled, so every strobed beat is
    // taken at the rising edge that ends its cycle and compared with the
    // oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d",
                     $realtime, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && result_valid)
        begin
            if (due_results.size() == 0)
            begin
                $display("[%0t] unexpected result beat: expected none, got %h",
                         $realtime, result);
                error_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("first_slot",     want.first_slot,     result.first_slot);
                check_field("second_slot",    want.second_slot,    result.second_slot);
                check_field("pair_found",     want.pair_found,     result.pair_found);
                check_field("first_handler",  want.first_handler,  result.first_handler);
                check_field("second_handler", want.second_handler, result.second_handler);
                check_field("table_full",     want.table_full,     result.table_full);
                check_field("last",           want.last,           result.last);
                if (result.pair_found === 1'b1)
                    pairs_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic in_beat_t box_cmd(int x, int y, int w, int h, bit handler);
        in_beat_t c;
        c             = '0;
        c.func        = FUNC_CREATE;
        c.x_pos       = x[15:0];
        c.y_pos       = y[15:0];
        c.box_width   = w[15:0];
        c.box_height  = h[15:0];
        c.has_handler = handler;
        return c;
    endfunction

    function automatic in_beat_t slot_cmd(logic [1:0] func, int slot, bit value);
        in_beat_t c;
        c              = '0;
        c.func         = func;
        c.slot         = slot[SLOT_W-1:0];
        c.active_value = value;
        return c;
    endfunction

    function automatic out_beat_t created_beat(int slot);
        out_beat_t o;
        o            = '0;
        o.first_slot = slot[SLOT_W-1:0];
        o.last       = 1'b1;
        return o;
    endfunction

    function automatic out_beat_t lone_beat(bit full);
        out_beat_t o;
        o            = '0;
        o.table_full = full;
        o.last       = 1'b1;
        return o;
    endfunction

    task automatic add_row(in_beat_t req, bit known, out_beat_t want);
        directed_row_t row;
        row.req   = req;
        row.known = known;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Random command. Positions and sizes mostly fall in a small cluster so
    // that ticks find overlaps often; a fifth of them span the whole range so
    // that every bit of every field toggles.
    function automatic in_beat_t random_cmd();
        in_beat_t    c;
        logic [95:0] noise;
        int          pick;
        noise = {$urandom, $urandom, $urandom};
        c     = noise[$bits(in_beat_t)-1:0];
        pick  = $urandom_range(0, 99);
        if (pick < 30)
        begin
            c.func = FUNC_CREATE;
            if ($urandom_range(0, 4) != 0)
            begin
                c.x_pos      = 16'($urandom_range(0, 2000)) - 16'd1000;
                c.y_pos      = 16'($urandom_range(0, 2000)) - 16'd1000;
                c.box_width  = 16'($urandom_range(0, 1200));
                c.box_height = 16'($urandom_range(0, 1200));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                c.box_width  = 16'hFFFF;
                c.box_height = 16'hFFFF;
            end
        end
        else if (pick < 50)
            c.func = FUNC_ERASE;
        else if (pick < 65)
        begin
            c.func         = FUNC_SET_ACTIVE;
            c.active_value = ($urandom_range(0, 3) != 0);
        end
        else
            c.func = FUNC_TICK;
        return c;
    endfunction

    // Holds start low with junk on the request bus for a random number of
    // cycles. It only ever lowers start, so start gets a single assignment
    // per falling edge.
    task automatic sender_gap(int idle_pct);
        logic [95:0] noise;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            noise = {$urandom, $urandom, $urandom};
            @(negedge clk);
            start   <= 1'b0;
            request <= noise[$bits(in_beat_t)-1:0];
            @(posedge clk);
        end
    endtask

    // Presents one command and waits for the block to take it. busy is read
    // at the rising edge before the block updates it, so the beat is taken
    // exactly at the first edge where busy was low. The prediction is made
    // at that same edge; no result of this beat can appear before the next.
    task automatic send_cmd(in_beat_t cmd, bit known, out_beat_t want);
        @(negedge clk);
        start   <= 1'b1;
        request <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_table_op(cmd);
        if (known)
            due_results.push_back(want);
        else
            foreach (step_results[k])
                due_results.push_back(step_results[k]);
        beats_sent++;
        if (cmd.func == FUNC_TICK)
            ticks_sent++;
        if (step_results.size() == 1 && step_results[0].table_full)
            full_creates++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int        phase_idle[3];
        out_beat_t none;

        phase_idle[0] = 0;
        phase_idle[1] = 69;
        phase_idle[2] = 14;
        none          = '0;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            shadow_valid[s]   = 1'b0;
            shadow_active[s]  = 1'b0;
            shadow_handler[s] = 1'b0;
            shadow_cx[s]      = '0;
            shadow_cy[s]      = '0;
            shadow_w[s]       = '0;
            shadow_h[s]       = '0;
        end

        // Directed table. A tick on the empty table gives the lone done beat.
        add_row(slot_cmd(FUNC_TICK, 0, 1'b0), 1'b1, lone_beat(1'b0));
        // Erase and set active on free slots change nothing visible.
        add_row(slot_cmd(FUNC_ERASE, 0, 1'b0), 1'b0, none);
        add_row(slot_cmd(FUNC_SET_ACTIVE, 7, 1'b1), 1'b0, none);
        // Opposite corners at full size only touch: 2*|dx| equals w1+w2.
        add_row(box_cmd(-32768, -32768, 65535, 65535, 1'b1), 1'b1, created_beat(0));
        add_row(box_cmd(32767, 32767, 65535, 65535, 1'b0), 1'b1, created_beat(1));
        add_row(slot_cmd(FUNC_TICK, 0, 1'b0), 1'b1, lone_beat(1'b0));
        // A zero-size box and a box that abuts it from the side.
        add_row(box_cmd(0, 0, 0, 0, 1'b1), 1'b1, created_beat(2));
        add_row(box_cmd(1, 0, 2, 2, 1'b0), 1'b1, created_beat(3));
        add_row(slot_cmd(FUNC_TICK, 0, 1'b0), 1'b0, none);
        // An inactive box drops out of the search, then comes back.
        add_row(slot_cmd(FUNC_SET_ACTIVE, 1, 1'b0), 1'b0, none);
        add_row(slot_cmd(FUNC_TICK, 0, 1'b0), 1'b0, none);
        add_row(slot_cmd(FUNC_SET_ACTIVE, 1, 1'b1), 1'b0, none);
        // Create reuses the lowest free slot after an erase.
        add_row(slot_cmd(FUNC_ERASE, 2, 1'b0), 1'b0, none);
        add_row(box_cmd(0, 0, 4, 4, 1'b1), 1'b1, created_beat(2));
        // Fill the table with large boxes so that a tick reports many pairs.
        add_row(box_cmd(0, 0, 65535, 65535, 1'b1), 1'b1, created_beat(4));
        add_row(box_cmd(100, -100, 65535, 65535, 1'b0), 1'b1, created_beat(5));
        add_row(box_cmd(-5, 7, 65535, 65535, 1'b1), 1'b1, created_beat(6));
        add_row(box_cmd(0, 0, 1, 1, 1'b0), 1'b1, created_beat(7));
        add_row(box_cmd(0, 0, 9, 9, 1'b1), 1'b1, lone_beat(1'b1));
        add_row(slot_cmd(FUNC_TICK, 0, 1'b0), 1'b0, none);
        add_row(slot_cmd(FUNC_SET_ACTIVE, 5, 1'b0), 1'b0, none);
        add_row(slot_cmd(FUNC_TICK, 0, 1'b0), 1'b0, none);
        add_row(slot_cmd(FUNC_ERASE, 7, 1'b0), 1'b0, none);

        // Reset is held low, then released at a falling edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, back to back.
        foreach (directed_rows[r])
            send_cmd(directed_rows[r].req, directed_rows[r].known, directed_rows[r].want);

        // Random part in three phases: the sender never idles, then idles
        // often, then only now and then. Gaps land anywhere in a tick's walk.
        for (int p = 0; p < 3; p++)
            for (int n = 0; n < RANDOM_BEATS / 3 + (p == 0 ? RANDOM_BEATS % 3 : 0); n++)
            begin
                sender_gap(phase_idle[p]);
                send_cmd(random_cmd(), 1'b0, none);
            end

        @(negedge clk);
        start <= 1'b0;

        // Wait for every predicted beat, then let a full tick's worth of
        // cycles pass so that any stray beat would still be caught.
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d commands including %0d ticks; %0d overlap beats checked,",
                 beats_sent, ticks_sent, pairs_seen);
        $display("up to %0d pairs in one tick, %0d creates refused on a full table.",
                 most_pairs, full_creates);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/aapo_pkg.sv
rtl/aapo_ctrl.sv
rtl/aapo_datapath.sv
rtl/aabb_all_pairs_overlap.sv
verif/tb.sv
